>>> hw/rtl/lpf_pkg.sv
`default_nettype none
// shared types, codes and constants for the lease proposer
package lpf_pkg;

  // proposal id layout: node id in the low bits
  localparam int NODE_BITS = 4;
  localparam int ID_W      = 32;
  localparam logic [ID_W-1:0] ID_MASK = ID_W'((64'd1 << NODE_BITS) - 64'd1);

  // field widths
  localparam int NODE_W = 4;
  localparam int NN_W   = 5;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 5;

  localparam logic [CNT_W-1:0]  CNT_MAX       = '1;
  localparam logic [TIME_W-1:0] CHOSEN_MARGIN = TIME_W'(500);

  // remaining lease / 7 via reciprocal multiply; at or above the limit the result saturates
  localparam int EXT_DIVISOR = 7;
  localparam int DIV_IN_W    = 19;
  localparam int DIV_SHIFT   = 22;
  localparam int DIV_MULT_W  = 20;
  localparam longint DIV_MULT  = ((64'd1 << DIV_SHIFT) + EXT_DIVISOR - 1) / EXT_DIVISOR;
  localparam longint DIV_LIMIT = longint'(EXT_DIVISOR) << DUR_W;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NODE_ID     = 2'd0,
    CFG_NUM_NODES   = 2'd1,
    CFG_LEASE_DUR   = 2'd2,
    CFG_ACQ_TIMEOUT = 2'd3
  } cfg_reg_t;

  // event codes
  typedef enum logic [2:0] {
    ACT_START   = 3'd0,
    ACT_STOP    = 3'd1,
    ACT_RESP    = 3'd2,
    ACT_ACQ_TMO = 3'd3,
    ACT_EXT_TMO = 3'd4
  } action_t;

  // acceptor response codes
  typedef enum logic [2:0] {
    RESP_PREP_REJECT = 3'd0,
    RESP_PREP_PREV   = 3'd1,
    RESP_PREP_OPEN   = 3'd2,
    RESP_PROP_REJECT = 3'd3,
    RESP_PROP_ACCEPT = 3'd4
  } resp_t;

  typedef enum logic [1:0] {
    MSG_NONE    = 2'd0,
    MSG_PREPARE = 2'd1,
    MSG_PROPOSE = 2'd2,
    MSG_CHOSEN  = 2'd3
  } msg_kind_t;

  typedef enum logic [1:0] {
    TMR_KEEP   = 2'd0,
    TMR_ARM    = 2'd1,
    TMR_CANCEL = 2'd2
  } timer_cmd_t;

  // proposer phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PREPARE = 2'd1,
    PH_PROPOSE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_id;
    logic [NN_W-1:0]   num_nodes;
    logic [DUR_W-1:0]  lease_duration;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [TIME_W-1:0] now;
    logic [2:0]        resp_type;
    logic [ID_W-1:0]   resp_proposal_id;
    logic [ID_W-1:0]   resp_accepted_id;
    logic [NODE_W-1:0] resp_lease_owner;
    logic [ID_W-1:0]   paxos_id;
  } in_word_t;

  typedef struct packed {
    msg_kind_t         msg_kind;
    logic [ID_W-1:0]   msg_proposal_id;
    logic [ID_W-1:0]   msg_paxos_id;
    logic [NODE_W-1:0] msg_lease_owner;
    logic [DUR_W-1:0]  msg_duration;
    logic [TIME_W-1:0] msg_expire_time;
    timer_cmd_t        acq_timer_cmd;
    timer_cmd_t        ext_timer_cmd;
    logic [DUR_W-1:0]  ext_timer_delay;
  } out_word_t;

  // handshake between pipeline stages
  typedef struct packed {
    logic advance;
    logic fire;
  } pipe_ctl_t;

endpackage
`default_nettype wire

>>> hw/rtl/lpf_cfg_regs.sv
`default_nettype none
// configuration registers of the lease proposer
module lpf_cfg_regs
  import lpf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [DUR_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_NODE_ID:     cfg_nxt.node_id        = cfg_wdata[NODE_W-1:0];
        CFG_NUM_NODES:   cfg_nxt.num_nodes      = cfg_wdata[NN_W-1:0];
        CFG_LEASE_DUR:   cfg_nxt.lease_duration = cfg_wdata;
        // acquire delay is applied by the external timer, nothing kept here
        CFG_ACQ_TIMEOUT: cfg_nxt = cfg_r;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_id        <= '0;
      cfg_r.num_nodes      <= NN_W'(3);
      cfg_r.lease_duration <= DUR_W'(7000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

>>> hw/rtl/lpf_in_stage.sv
`default_nettype none
// input register stage for event words
module lpf_in_stage
  import lpf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  in_word_t      in_data,
  input  wire logic     advance,
  output pipe_ctl_t     ctl,
  output in_word_t      item
);

  logic     vld_r, vld_nxt;
  in_word_t data_r, data_nxt;
  logic     accept;

  // stall only while a held word cannot move on
  assign in_stall = vld_r && !advance;
  assign accept   = in_valid && !in_stall;

  assign ctl.advance = advance;
  assign ctl.fire    = vld_r && advance;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (accept) begin
      vld_nxt  = 1'b1;
      data_nxt = in_data;
    end else if (ctl.fire) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign item = data_r;

endmodule
`default_nettype wire

>>> hw/rtl/lpf_core.sv
`default_nettype none
// proposer state and single-pass event evaluation
module lpf_core
  import lpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  pipe_ctl_t ctl,
  input  in_word_t  item,
  input  cfg_t      cfg,
  output out_word_t result
);

  // protocol state
  phase_t            phase_r, phase_nxt;
  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic [ID_W-1:0]   high_r, high_nxt;
  logic [ID_W-1:0]   hsa_r, hsa_nxt;
  logic [NODE_W-1:0] own_r, own_nxt;
  logic [TIME_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0]  rep_r, rep_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [CNT_W-1:0]  rej_r, rej_nxt;

  // event decode
  logic act_start, act_stop, act_resp, act_tmo;
  logic is_prep_resp, is_prop_resp;

  // decisions
  logic              prep_hit, prop_hit, owner_upd;
  logic              prep_restart, prep_major, propose_go, chosen, prop_restart;
  logic              start_prep, clr_cnt;
  logic [CNT_W-1:0]  rep_cnt, rej_cnt, acc_cnt;
  logic [CNT_W-1:0]  majority, rej_thr;
  logic [NODE_W-1:0] own_new;
  logic [ID_W-1:0]   id_bits, next_id;
  logic [TIME_W-1:0] left;

  // extend delay divider
  logic [DIV_MULT_W-1:0]          div_mult;
  logic [DIV_IN_W+DIV_MULT_W-1:0] div_prod;
  logic [DUR_W-1:0]               ext_delay, left_sat;

  always_comb begin
    act_start = 1'b0;
    act_stop  = 1'b0;
    act_resp  = 1'b0;
    act_tmo   = 1'b0;
    case (item.action)
      ACT_START:   act_start = ctl.fire;
      ACT_STOP:    act_stop  = ctl.fire;
      ACT_RESP:    act_resp  = ctl.fire;
      ACT_ACQ_TMO: act_tmo   = ctl.fire;
      ACT_EXT_TMO: act_tmo   = ctl.fire;
      default:     act_tmo   = 1'b0;
    endcase
  end

  assign is_prep_resp = item.resp_type inside {RESP_PREP_REJECT, RESP_PREP_PREV, RESP_PREP_OPEN};
  assign is_prop_resp = item.resp_type inside {RESP_PROP_REJECT, RESP_PROP_ACCEPT};

  // thresholds from group size
  assign majority = (cfg.num_nodes >> 1) + CNT_W'(1);
  assign rej_thr  = CNT_W'(({1'b0, cfg.num_nodes} + (NN_W+1)'(1)) >> 1);

  // saturating counter steps
  assign rep_cnt = (rep_r == CNT_MAX) ? rep_r : rep_r + CNT_W'(1);
  assign rej_cnt = (item.resp_type == RESP_PREP_REJECT && rej_r != CNT_MAX) ?
                   rej_r + CNT_W'(1) : rej_r;
  assign acc_cnt = (item.resp_type == RESP_PROP_ACCEPT && acc_r != CNT_MAX) ?
                   acc_r + CNT_W'(1) : acc_r;

  // next proposal id: bump the round above the highest seen, add node id
  assign id_bits = ID_W'(cfg.node_id) & ID_MASK;
  assign next_id = (((high_r >> NODE_BITS) + ID_W'(1)) << NODE_BITS) | id_bits;

  assign left = exp_r - item.now;

  // prepare response handling
  assign prep_hit     = act_resp && is_prep_resp && (phase_r == PH_PREPARE) &&
                        (item.resp_proposal_id == cur_r);
  assign owner_upd    = prep_hit && (item.resp_type == RESP_PREP_PREV) &&
                        (item.resp_accepted_id >= hsa_r);
  assign own_new      = owner_upd ? item.resp_lease_owner : own_r;
  assign prep_restart = prep_hit && (rej_cnt >= rej_thr);
  assign prep_major   = prep_hit && !prep_restart && ((rep_cnt - rej_cnt) >= majority);
  assign propose_go   = prep_major && (own_new == cfg.node_id);

  // propose response handling, late responses are dropped
  assign prop_hit     = act_resp && is_prop_resp && !(exp_r < item.now) &&
                        (phase_r == PH_PROPOSE) && (item.resp_proposal_id == cur_r);
  assign chosen       = prop_hit && (acc_cnt >= majority) && (left > CHOSEN_MARGIN);
  assign prop_restart = prop_hit && !chosen && (rep_cnt == cfg.num_nodes);

  assign start_prep = (act_start && phase_r == PH_IDLE) || act_tmo ||
                      prep_restart || prop_restart;
  assign clr_cnt    = start_prep || propose_go || chosen;

  // remaining lease divided by 7, saturated to 16 bits
  assign div_mult  = DIV_MULT_W'(DIV_MULT);
  assign div_prod  = left[DIV_IN_W-1:0] * div_mult;
  assign ext_delay = (left >= TIME_W'(DIV_LIMIT)) ? '1 : div_prod[DIV_SHIFT +: DUR_W];
  assign left_sat  = (left > TIME_W'({DUR_W{1'b1}})) ? '1 : left[DUR_W-1:0];

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (start_prep) begin
      phase_nxt = PH_PREPARE;
    end else if (act_stop) begin
      phase_nxt = PH_IDLE;
    end else if (propose_go) begin
      phase_nxt = PH_PROPOSE;
    end else if (prep_major || chosen) begin
      phase_nxt = PH_IDLE;
    end
  end

  // datapath state
  always_comb begin
    cur_nxt  = cur_r;
    high_nxt = high_r;
    hsa_nxt  = hsa_r;
    own_nxt  = own_new;
    exp_nxt  = exp_r;
    rep_nxt  = rep_r;
    acc_nxt  = acc_r;
    rej_nxt  = rej_r;
    if (owner_upd) begin
      hsa_nxt = item.resp_accepted_id;
    end
    if (prep_hit) begin
      rep_nxt = rep_cnt;
      rej_nxt = rej_cnt;
    end
    if (prop_hit) begin
      rep_nxt = rep_cnt;
      acc_nxt = acc_cnt;
    end
    if (propose_go) begin
      exp_nxt = item.now + TIME_W'(cfg.lease_duration);
    end
    if (start_prep) begin
      cur_nxt = next_id;
      hsa_nxt = '0;
      own_nxt = cfg.node_id;
      if (next_id > high_r) begin
        high_nxt = next_id;
      end
    end
    if (clr_cnt) begin
      rep_nxt = '0;
      acc_nxt = '0;
      rej_nxt = '0;
    end
  end

  // result word
  always_comb begin
    result = '0;
    if (act_start || act_stop) begin
      result.ext_timer_cmd = TMR_CANCEL;
    end
    if (act_stop) begin
      result.acq_timer_cmd = TMR_CANCEL;
    end
    if (start_prep) begin
      result.msg_kind        = MSG_PREPARE;
      result.msg_proposal_id = next_id;
      result.msg_paxos_id    = item.paxos_id;
      result.acq_timer_cmd   = TMR_ARM;
    end else if (propose_go) begin
      result.msg_kind        = MSG_PROPOSE;
      result.msg_proposal_id = cur_r;
      result.msg_lease_owner = own_new;
      result.msg_duration    = cfg.lease_duration;
    end else if (chosen) begin
      result.msg_kind        = MSG_CHOSEN;
      result.msg_lease_owner = own_r;
      result.msg_duration    = left_sat;
      result.msg_expire_time = exp_r;
      result.acq_timer_cmd   = TMR_CANCEL;
      result.ext_timer_cmd   = TMR_ARM;
      result.ext_timer_delay = ext_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cur_r   <= '0;
      high_r  <= '0;
      hsa_r   <= '0;
      own_r   <= '0;
      exp_r   <= '0;
      rep_r   <= '0;
      acc_r   <= '0;
      rej_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      high_r  <= high_nxt;
      hsa_r   <= hsa_nxt;
      own_r   <= own_nxt;
      exp_r   <= exp_nxt;
      rep_r   <= rep_nxt;
      acc_r   <= acc_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // rejects and accepts are each a subset of the replies
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    (rej_r <= rep_r) && (acc_r <= rep_r))
    else $error("reply counters out of order");

  // a new proposal always carries this node's id in its low bits
  a_prep_id: assert property (@(posedge clk) disable iff (!rst_n)
    start_prep |=> ((cur_r & ID_MASK) == ($past(id_bits))))
    else $error("proposal id lost node id");

  // sending any message clears the counters
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_cnt |=> (rep_r == '0) && (acc_r == '0) && (rej_r == '0))
    else $error("counters not cleared on send");

  // a chosen lease ends the proposing phase
  a_chosen_idle: assert property (@(posedge clk) disable iff (!rst_n)
    chosen |=> (phase_r == PH_IDLE))
    else $error("still proposing after chosen");

  // state only moves when a word is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.fire |=> $stable(phase_r) && $stable(cur_r) && $stable(rep_r))
    else $error("state changed without an event");

endmodule
`default_nettype wire

>>> hw/rtl/lpf_out_stage.sv
`default_nettype none
// result register stage toward the consumer
module lpf_out_stage
  import lpf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  pipe_ctl_t ctl,
  input  out_word_t result,
  output logic      advance,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_data
);

  logic      vld_r, vld_nxt;
  out_word_t data_r, data_nxt;

  // room when empty or the held word leaves this cycle
  assign advance = !vld_r || !out_stall;

  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    if (ctl.fire) begin
      vld_nxt  = 1'b1;
      data_nxt = result;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

>>> hw/rtl/lease_proposer_fsm_top.sv
// an accepted event word is evaluated from the input register, and its result is held in the result register
// throughput: one event per cycle while out_stall does not hold the result register; the input register,
//   the evaluation logic and the result register form a two-stage pipeline
// reset: synchronous active-low rst_n empties both stages, returns the proposer to idle
//   with cleared ids and counters, and loads node_id 0, num_nodes 3, lease_duration 7000
`default_nettype none
module lease_proposer_fsm_top
  import lpf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_word_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [DUR_W-1:0] cfg_wdata
);

  cfg_t      cfg;
  pipe_ctl_t ctl;
  in_word_t  item;
  out_word_t result;
  logic      advance;

  // configuration
  lpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input word register
  lpf_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .advance  (advance),
    .ctl      (ctl),
    .item     (item)
  );

  // proposer state and evaluation
  lpf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  // result word register
  lpf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
